// ----- hdl/updec_pkg.sv -----
// ----------------------------------------------------------------------------
// updec_pkg
// Shared types, character constants and hex helpers for the URI decoder.
// ----------------------------------------------------------------------------
package updec_pkg;

    // Characters that steer decoding
    localparam logic [7:0] CH_PCT   = 8'h25;   // '%'
    localparam logic [7:0] CH_QMARK = 8'h3F;   // '?'
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NBSP  = 8'd160;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Most bytes one item can produce, and width of a count of them
    localparam int RES_MAX = 3;
    localparam int CNT_W   = 2;

    // Escape hold codes
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [1:0] held_count;
        logic [7:0] held_digit;
        logic       in_query;
        logic       lower_done;
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       uri_end;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        res_t [RES_MAX-1:0]       items;
        state_t                   state_next;
    } dec_out_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ----- hdl/updec_decode.sv -----
// ----------------------------------------------------------------------------
// updec_decode
// Single-pass decode of one raw byte: escape tracking, flush on the final
// byte and lowercasing of up to three output bytes.
// ----------------------------------------------------------------------------
module updec_decode
    import updec_pkg::*;
(
    input  logic [7:0] raw_byte,
    input  logic       is_final,
    input  logic       case_sensitive,
    input  state_t     state,
    output dec_out_t   dec
);

    always_comb
    begin
        logic [7:0]       raw_q [RES_MAX];
        logic [CNT_W-1:0] cnt;
        logic [1:0]       nhc;
        logic [7:0]       nd;
        logic             nq;
        logic             ld;
        logic             fresh;
        logic [7:0]       v;
        logic [7:0]       b;

        for (int i = 0; i < RES_MAX; i++)
        begin
            raw_q[i] = CH_NUL;
        end
        cnt   = '0;
        nhc   = HELD_NONE;
        nd    = state.held_digit;
        fresh = 1'b0;
        v     = {hex_val(state.held_digit), hex_val(raw_byte)};
        if (v == CH_SPACE)
        begin
            v = CH_NBSP;
        end

        // escape progress
        case (state.held_count)
            HELD_PCT:
            begin
                if (is_hex(raw_byte))
                begin
                    nhc = HELD_DIGIT;
                    nd  = raw_byte;
                end
                else
                begin
                    raw_q[cnt] = CH_PCT;
                    cnt        = cnt + 1'b1;
                    fresh      = 1'b1;
                end
            end
            HELD_DIGIT:
            begin
                if (is_hex(raw_byte))
                begin
                    raw_q[cnt] = v;
                    cnt        = cnt + 1'b1;
                end
                else
                begin
                    raw_q[cnt] = CH_PCT;
                    cnt        = cnt + 1'b1;
                    raw_q[cnt] = state.held_digit;
                    cnt        = cnt + 1'b1;
                    fresh      = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // byte taken as new
        nq = state.in_query | (fresh && raw_byte == CH_QMARK);
        if (fresh)
        begin
            if (!state.in_query && raw_byte == CH_PCT)
            begin
                nhc = HELD_PCT;
            end
            else
            begin
                raw_q[cnt] = raw_byte;
                cnt        = cnt + 1'b1;
            end
        end

        // flush held bytes at end of URI
        if (is_final)
        begin
            if (nhc == HELD_PCT || nhc == HELD_DIGIT)
            begin
                raw_q[cnt] = CH_PCT;
                cnt        = cnt + 1'b1;
            end
            if (nhc == HELD_DIGIT)
            begin
                raw_q[cnt] = nd;
                cnt        = cnt + 1'b1;
            end
        end

        // lowercasing chain, one step per output byte
        ld = state.lower_done;
        for (int i = 0; i < RES_MAX; i++)
        begin
            b = raw_q[i];
            if (CNT_W'(i) < cnt && !ld)
            begin
                if (b == CH_NUL || b == CH_QMARK)
                begin
                    ld = 1'b1;
                end
                else if (!case_sensitive && b >= CH_UP_A && b <= CH_UP_Z)
                begin
                    b = b + CASE_OFS;
                end
            end
            dec.items[i].data    = b;
            dec.items[i].last    = (CNT_W'(i) == cnt - 1'b1);
            dec.items[i].uri_end = (CNT_W'(i) == cnt - 1'b1) && is_final;
        end

        dec.count = cnt;
        if (is_final)
        begin
            dec.state_next = '0;
        end
        else
        begin
            dec.state_next.held_count = nhc;
            dec.state_next.held_digit = nd;
            dec.state_next.in_query   = nq;
            dec.state_next.lower_done = ld;
        end
    end

endmodule

// ----- hdl/updec_out_buf.sv -----
// ----------------------------------------------------------------------------
// updec_out_buf
// Result buffer of up to three decoded bytes, drained one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module updec_out_buf
    import updec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dec_out_t           dec,
    input  logic               out_stall,
    output logic               can_load,
    output logic               out_valid,
    output res_t               head
);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    res_t [RES_MAX-1:0] slot_reg;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign head      = slot_reg[0];
    assign pop       = out_valid && !out_stall;

    // room for a new item once the buffer will be empty
    assign can_load  = (count_reg == '0) || (count_reg == CNT_W'(1) && pop);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (load)
        begin
            count_next = dec.count;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload slots: load all, or shift toward the head
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= dec.items;
        end
        else if (pop)
        begin
            for (int i = 0; i < RES_MAX - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

// ----- hdl/uri_percent_decoder.sv -----
// Path: an accepted item waits in the input register while the result buffer
// has no room; its result is then offered from the result buffer.
// Throughput: one item per cycle while each item gives at most one byte and
// out_stall is low; an item giving more bytes stalls the input while they drain.
// Reset: rst_n clears decode state, case_sensitive and both valid flags.
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming percent-decoder for a request URI: input register, single-pass
// decode, result buffer.
// ----------------------------------------------------------------------------
module uri_percent_decoder
    import updec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       uri_end
);

    logic       case_sens_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;
    state_t     state_reg;
    dec_out_t   dec;
    logic       can_load;
    logic       move;
    logic       accept;
    res_t       head;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sens_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case_sens_reg <= cfg_wr_data;
        end
    end

    // input register handshake
    assign move     = in_valid_reg && can_load;
    assign in_stall = in_valid_reg && !can_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= raw_byte;
            in_final_reg <= is_final;
        end
    end

    // decode
    updec_decode u_decode (
        .raw_byte       (in_byte_reg),
        .is_final       (in_final_reg),
        .case_sensitive (case_sens_reg),
        .state          (state_reg),
        .dec            (dec)
    );

    // decode state advances as the item enters the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (move)
        begin
            state_reg <= dec.state_next;
        end
    end

    // result buffer
    updec_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .dec       (dec),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .head      (head)
    );

    assign out_byte = head.data;
    assign out_last = head.last;
    assign uri_end  = head.uri_end;

`ifndef NO_ASSERTIONS
    // a final item leaves the decode state at reset values
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_final_reg) |=> (state_reg.held_count == HELD_NONE &&
                                    !state_reg.in_query && !state_reg.lower_done))
        else $error("decode state not cleared after final item");

    // escapes are only held outside the query part
    a_hold_no_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.held_count != HELD_NONE) |-> !state_reg.in_query)
        else $error("escape held inside query");

    // end of URI only on the last byte of an item
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && uri_end) |-> out_last)
        else $error("uri_end without out_last");
`endif

endmodule
